// ===== src/adsr_envelope_generator_defines.svh =====
// assertion helpers for the envelope generator, sampled on aclk, off while aresetn is low
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ADSR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adsr: same-cycle check failed");
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adsr: next-cycle check failed");
`else
`define ADSR_ASSERT_IMPL(lbl, ante, cons)
`define ADSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    localparam int          SAMPLES_W = 20;
    localparam int          ADDR_W    = 4;
    localparam logic [15:0] ONE_Q15   = 16'h8000;

    localparam logic [SAMPLES_W-1:0] ATTACK_RESET  = 20'd4800;
    localparam logic [SAMPLES_W-1:0] DECAY_RESET   = 20'd4800;
    localparam logic [15:0]          SUSTAIN_RESET = 16'd22938;
    localparam logic [SAMPLES_W-1:0] RELEASE_RESET = 20'd14400;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } cmd_e_t;

    typedef enum logic [2:0] {
        STAGE_IDLE    = 3'd0,
        STAGE_ATTACK  = 3'd1,
        STAGE_DECAY   = 3'd2,
        STAGE_SUSTAIN = 3'd3,
        STAGE_RELEASE = 3'd4
    } stage_e_t;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } reg_idx_e_t;

    typedef struct packed {
        logic [SAMPLES_W-1:0] attack_samples;
        logic [SAMPLES_W-1:0] decay_samples;
        logic [15:0]          sustain_level;
        logic [SAMPLES_W-1:0] release_samples;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] source_sample;
        logic [15:0]        velocity;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic [15:0]        amplitude;
        logic [2:0]         stage;
        logic               is_active;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== src/adsr_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_apb_regs
    import adsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_idx_e_t reg_idx;

    assign reg_idx = reg_idx_e_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ATTACK:  cfg_next.attack_samples  = pwdata[SAMPLES_W-1:0];
                REG_DECAY:   cfg_next.decay_samples   = pwdata[SAMPLES_W-1:0];
                REG_SUSTAIN: cfg_next.sustain_level   = pwdata[15:0];
                REG_RELEASE: cfg_next.release_samples = pwdata[SAMPLES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ATTACK:  prdata = 32'(cfg_reg.attack_samples);
            REG_DECAY:   prdata = 32'(cfg_reg.decay_samples);
            REG_SUSTAIN: prdata = 32'(cfg_reg.sustain_level);
            REG_RELEASE: prdata = 32'(cfg_reg.release_samples);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack_samples  <= ATTACK_RESET;
            cfg_reg.decay_samples   <= DECAY_RESET;
            cfg_reg.sustain_level   <= SUSTAIN_RESET;
            cfg_reg.release_samples <= RELEASE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/adsr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adsr_div
    import adsr_pkg::*;
#(
    parameter int DIVIDEND_W = 35,
    parameter int DIVISOR_W  = 20
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // restoring long division, one quotient bit per cycle, msb first
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_generator_defines.svh"

// Linear ADSR envelope on Q1.15 amplitudes (0x8000 is full scale). Each input beat
// is a note-on, a note-off or a sample tick; only ticks produce an output beat,
// carrying source*amplitude*velocity>>30 together with the new amplitude, stage and
// active flag. Note-on and note-off beats are absorbed in the cycle they are taken.
// A tick while the envelope is idle goes straight to the emit state, with s_ready
// low until its result has been issued. A tick in any other stage runs one product
// through the shared multiplier, one restoring division by the stage length (one
// quotient bit per cycle), then two more passes through the multiplier for the output
// gain: s_ready stays low from acceptance until the result is issued, and m_valid
// rises as s_ready returns high, so no new beat is taken while a tick is in flight.
// The dividend is DW = max(COUNT_BITS + 15, 35) bits wide. A result still
// waiting on m_ready holds the block until it is taken. Stage lengths and sustain
// level are set over the APB port (attack 0x0, decay 0x4, sustain 0x8, release 0xC);
// the user is to write them between notes, which the block itself does not enforce.
module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_beat_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_beat_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int MW   = (COUNT_BITS > 31) ? COUNT_BITS : 31;
    localparam int PW   = MW + 18;
    localparam int DW   = (COUNT_BITS + 15 > 35) ? COUNT_BITS + 15 : 35;
    localparam int CMPW = (COUNT_BITS > SAMPLES_W) ? COUNT_BITS : SAMPLES_W;

    typedef enum logic [5:0] {
        SEQ_IDLE  = 6'b000001,
        SEQ_PROD  = 6'b000010,
        SEQ_DIV   = 6'b000100,
        SEQ_GAIN  = 6'b001000,
        SEQ_SCALE = 6'b010000,
        SEQ_EMIT  = 6'b100000
    } seq_e_t;

    cfg_t cfg;

    seq_e_t                 seq_reg, seq_next;
    stage_e_t               stage_reg, stage_next;
    logic [15:0]            amp_reg, amp_next;
    logic [15:0]            gain_reg, gain_next;
    logic [15:0]            atk_start_reg, atk_start_next;
    logic [15:0]            rel_start_reg, rel_start_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                   active_reg, active_next;
    logic signed [15:0]     sample_reg, sample_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic                   m_valid_reg, m_valid_next;
    out_beat_t              m_data_reg, m_data_next;

    logic [15:0]            eff_sus;
    logic [15:0]            diff_a;
    logic [15:0]            diff_d;
    logic [CMPW-1:0]        cnt_ext;
    logic [CMPW-1:0]        rel_left;
    logic                   cnt_ge_d;
    logic                   cnt_lt_r;
    logic [COUNT_BITS-1:0]  cnt_inc;

    logic signed [16:0]     mul_a;
    logic [MW-1:0]          mul_b_u;
    logic signed [MW:0]     mul_b;
    logic signed [PW-1:0]   prod_full;

    logic                   div_start;
    logic                   div_done;
    logic [SAMPLES_W-1:0]   div_divisor;
    logic [DW-1:0]          quo;

    adsr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adsr_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (SAMPLES_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_full[DW-1:0]),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign eff_sus  = (cfg.sustain_level > ONE_Q15) ? ONE_Q15 : cfg.sustain_level;
    assign diff_a   = ONE_Q15 - atk_start_reg;
    // decay always starts from full scale
    assign diff_d   = ONE_Q15 - eff_sus;
    assign cnt_ext  = CMPW'(cnt_reg);
    assign rel_left = CMPW'(cfg.release_samples) - cnt_ext;
    assign cnt_ge_d = cnt_ext >= CMPW'(cfg.decay_samples);
    assign cnt_lt_r = cnt_ext < CMPW'(cfg.release_samples);
    assign cnt_inc  = (&cnt_reg) ? cnt_reg : cnt_reg + COUNT_BITS'(1);

    // shared multiplier operands
    always_comb begin
        mul_a       = '0;
        mul_b_u     = '0;
        div_divisor = cfg.decay_samples;
        unique case (seq_reg)
            SEQ_PROD: begin
                unique case (stage_reg)
                    STAGE_ATTACK: begin
                        mul_a       = $signed({1'b0, diff_a});
                        mul_b_u     = MW'(cnt_reg);
                        div_divisor = cfg.attack_samples;
                    end
                    STAGE_DECAY: begin
                        mul_a   = $signed({1'b0, diff_d});
                        mul_b_u = MW'(cnt_reg);
                    end
                    STAGE_RELEASE: begin
                        mul_a       = $signed({1'b0, rel_start_reg});
                        mul_b_u     = cnt_lt_r ? MW'(rel_left) : '0;
                        div_divisor = cfg.release_samples;
                    end
                    default: ;
                endcase
            end
            SEQ_GAIN: begin
                mul_a   = $signed({1'b0, amp_reg});
                mul_b_u = MW'(gain_reg);
            end
            SEQ_SCALE: begin
                mul_a   = $signed({sample_reg[15], sample_reg});
                mul_b_u = MW'(prod_reg[30:0]);
            end
            default: ;
        endcase
    end

    assign mul_b     = $signed({1'b0, mul_b_u});
    assign prod_full = mul_a * mul_b;

    assign s_ready = (seq_reg == SEQ_IDLE);

    always_comb begin
        seq_next       = seq_reg;
        stage_next     = stage_reg;
        amp_next       = amp_reg;
        gain_next      = gain_reg;
        atk_start_next = atk_start_reg;
        rel_start_next = rel_start_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        div_start      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_e_t'(s_data.command))
                        CMD_TICK: begin
                            sample_next = s_data.source_sample;
                            seq_next    = (stage_reg == STAGE_IDLE) ? SEQ_EMIT : SEQ_PROD;
                        end
                        CMD_NOTE_ON: begin
                            gain_next      = (s_data.velocity > ONE_Q15) ? ONE_Q15
                                                                         : s_data.velocity;
                            stage_next     = STAGE_ATTACK;
                            atk_start_next = amp_reg;
                            cnt_next       = '0;
                            active_next    = 1'b1;
                        end
                        CMD_NOTE_OFF: begin
                            rel_start_next = (stage_reg == STAGE_SUSTAIN) ? eff_sus : amp_reg;
                            stage_next     = STAGE_RELEASE;
                            cnt_next       = '0;
                        end
                        default: ;
                    endcase
                end
            end
            SEQ_PROD: begin
                div_start = 1'b1;
                seq_next  = SEQ_DIV;
            end
            SEQ_DIV: begin
                if (div_done) begin
                    seq_next = SEQ_GAIN;
                    unique case (stage_reg)
                        STAGE_ATTACK: begin
                            if (cfg.attack_samples == '0 || quo >= DW'(diff_a)) begin
                                amp_next   = ONE_Q15;
                                stage_next = STAGE_DECAY;
                                cnt_next   = '0;
                            end else begin
                                amp_next = atk_start_reg + quo[15:0];
                                cnt_next = cnt_inc;
                            end
                        end
                        STAGE_DECAY: begin
                            if (cfg.decay_samples == '0 || cnt_ge_d) begin
                                amp_next   = eff_sus;
                                stage_next = STAGE_SUSTAIN;
                            end else begin
                                amp_next = (quo > DW'(ONE_Q15)) ? 16'd0 : ONE_Q15 - quo[15:0];
                                cnt_next = cnt_inc;
                            end
                        end
                        STAGE_SUSTAIN: begin
                            amp_next = eff_sus;
                            cnt_next = cnt_inc;
                        end
                        STAGE_RELEASE: begin
                            if (cfg.release_samples == '0 || !cnt_lt_r) begin
                                amp_next    = '0;
                                stage_next  = STAGE_IDLE;
                                active_next = 1'b0;
                            end else begin
                                amp_next = quo[15:0];
                                cnt_next = cnt_inc;
                            end
                        end
                        default: amp_next = '0;
                    endcase
                end
            end
            SEQ_GAIN: begin
                prod_next = prod_full;
                seq_next  = SEQ_SCALE;
            end
            SEQ_SCALE: begin
                prod_next = prod_full;
                seq_next  = SEQ_EMIT;
            end
            SEQ_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    // floor shift by 30 is the bit slice of the signed product
                    m_data_next.out_sample = (stage_reg == STAGE_IDLE) ? 16'sd0
                                                                       : prod_reg[45:30];
                    m_data_next.amplitude  = amp_reg;
                    m_data_next.stage      = stage_reg;
                    m_data_next.is_active  = active_reg;
                    seq_next               = SEQ_IDLE;
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= SEQ_IDLE;
            stage_reg     <= STAGE_IDLE;
            amp_reg       <= '0;
            gain_reg      <= ONE_Q15;
            atk_start_reg <= '0;
            rel_start_reg <= '0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            stage_reg     <= stage_next;
            amp_reg       <= amp_next;
            gain_reg      <= gain_next;
            atk_start_reg <= atk_start_next;
            rel_start_reg <= rel_start_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ADSR_ASSERT_IMPL(a_amp_bound, 1'b1, amp_reg <= ONE_Q15)
    `ADSR_ASSERT_IMPL(a_inactive_stage, !active_reg, stage_reg == STAGE_IDLE || stage_reg == STAGE_RELEASE)
    `ADSR_ASSERT_NEXT(a_tick_blocks, s_valid && s_ready && s_data.command == CMD_TICK, !s_ready)
    `ADSR_ASSERT_IMPL(a_done_in_div, div_done, seq_reg == SEQ_DIV)

endmodule

`default_nettype wire
